@@ design/kpsd_pkg.sv @@
`timescale 1ns / 1ps

package kpsd_pkg;

   localparam int unsigned NUM_ROWS = 4;
   localparam int unsigned NUM_COLS = 4;
   localparam int unsigned ROW_W    = 2;
   localparam int unsigned CODE_W   = 8;
   localparam int unsigned COUNT_W  = 8;

   localparam logic [NUM_COLS-1:0] COLS_IDLE          = 4'hF;
   localparam logic [COUNT_W-1:0]  RELEASE_TICKS_RST  = 8'd8;

   // scan state carried from one tick to the next
   typedef struct packed {
      logic [ROW_W-1:0]   next_row;
      logic [ROW_W-1:0]   scanned_row;
      logic               locked;
      logic [COUNT_W-1:0] release_count;
   } scan_state_type;

   // one result item
   typedef struct packed {
      logic [NUM_ROWS-1:0] row_drive;
      logic                key_event;
      logic [CODE_W-1:0]   key_code;
   } scan_result_type;

   // ASCII legend of the 4x4 pad, row by column
   function automatic logic [CODE_W-1:0] key_lookup(input logic [ROW_W-1:0] row,
                                                    input logic [1:0]       col);
      logic [CODE_W-1:0] code;
      code = 8'h00;
      case ({row, col})
         4'h0: code = 8'h31; // '1'
         4'h1: code = 8'h32; // '2'
         4'h2: code = 8'h33; // '3'
         4'h3: code = 8'h41; // 'A'
         4'h4: code = 8'h34; // '4'
         4'h5: code = 8'h35; // '5'
         4'h6: code = 8'h36; // '6'
         4'h7: code = 8'h42; // 'B'
         4'h8: code = 8'h37; // '7'
         4'h9: code = 8'h38; // '8'
         4'hA: code = 8'h39; // '9'
         4'hB: code = 8'h43; // 'C'
         4'hC: code = 8'h2A; // '*'
         4'hD: code = 8'h30; // '0'
         4'hE: code = 8'h23; // '#'
         default: code = 8'h44; // 'D'
      endcase
      return code;
   endfunction

endpackage

@@ design/matrix_keypad_scan_debounce_unit.sv @@
`timescale 1ns / 1ps

// 4x4 matrix keypad scanner. Each req_ transfer is one scan tick carrying the
// active-low column levels, read against the row driven on the previous tick;
// each tick yields one rsp_ item with the row pattern to drive next, a one-tick
// key event and the key's ASCII code (0 when no event). After a key is taken
// the scanner stays locked until release_ticks+1 consecutive all-high ticks
// have passed; any low column reloads the count.
// One tick is taken per clock while no result is stalled: the whole tick is a
// single pass of logic into the result register, and a new tick is accepted in
// the cycle its predecessor's result is taken; its result shows the next cycle.
module matrix_keypad_scan_debounce_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [kpsd_pkg::COUNT_W-1:0]  csr_wr_data,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [kpsd_pkg::NUM_COLS-1:0] req_col_levels,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [kpsd_pkg::NUM_ROWS-1:0] rsp_row_drive,
   output logic                          rsp_key_event,
   output logic [kpsd_pkg::CODE_W-1:0]   rsp_key_code
);

   logic [kpsd_pkg::COUNT_W-1:0] release_ticks_ff;
   kpsd_pkg::scan_state_type     state_ff;
   kpsd_pkg::scan_state_type     state_in;
   kpsd_pkg::scan_result_type    result_ff;
   kpsd_pkg::scan_result_type    result_in;
   logic                         rsp_valid_ff;
   logic                         req_xfer;

   // stall only while a result waits and the consumer is stalling
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_xfer  = req_valid && !req_stall;

   kpsd_step u_step (
      .cur           (state_ff),
      .col_levels    (req_col_levels),
      .release_ticks (release_ticks_ff),
      .nxt           (state_in),
      .res           (result_in)
   );

   // hold the release length
   always_ff @(posedge clock) begin
      if (reset) begin
         release_ticks_ff <= kpsd_pkg::RELEASE_TICKS_RST;
      end else if (csr_wr_en) begin
         release_ticks_ff <= csr_wr_data;
      end
   end

   // advance the scan state on each input transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (req_xfer) begin
         state_ff <= state_in;
      end
   end

   // result register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_xfer) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_row_drive = result_ff.row_drive;
   assign rsp_key_event = result_ff.key_event;
   assign rsp_key_code  = result_ff.key_code;

endmodule

@@ design/kpsd_step.sv @@
`timescale 1ns / 1ps

// One scan tick: key pick, lock and release countdown, row advance.
module kpsd_step (
   input  kpsd_pkg::scan_state_type      cur,
   input  logic [kpsd_pkg::NUM_COLS-1:0] col_levels,
   input  logic [kpsd_pkg::COUNT_W-1:0]  release_ticks,
   output kpsd_pkg::scan_state_type      nxt,
   output kpsd_pkg::scan_result_type     res
);

   logic       any_low;
   logic       all_high;
   logic [1:0] low_col;
   logic       lock_mid;

   assign all_high = (col_levels == kpsd_pkg::COLS_IDLE);
   assign any_low  = !all_high;

   // find the lowest-numbered pressed column
   always_comb begin
      if (!col_levels[0]) begin
         low_col = 2'd0;
      end else if (!col_levels[1]) begin
         low_col = 2'd1;
      end else if (!col_levels[2]) begin
         low_col = 2'd2;
      end else begin
         low_col = 2'd3;
      end
   end

   // detect a new key while unlocked
   assign res.key_event = !cur.locked && any_low;
   assign res.key_code  = res.key_event ?
                          kpsd_pkg::key_lookup(cur.scanned_row, low_col) : 8'h00;
   assign lock_mid      = cur.locked || any_low;

   // reload on a press, count down on idle ticks, release at zero;
   // drive the next row low and advance
   always_comb begin
      nxt.locked        = lock_mid;
      nxt.release_count = cur.release_count;
      nxt.scanned_row   = cur.next_row;
      nxt.next_row      = cur.next_row + 1'b1;
      if (lock_mid) begin
         if (all_high) begin
            if (cur.release_count != '0) begin
               nxt.release_count = cur.release_count - 1'b1;
            end else begin
               nxt.locked = 1'b0;
            end
         end else begin
            nxt.release_count = release_ticks;
         end
      end
   end

   assign res.row_drive = ~(kpsd_pkg::NUM_ROWS'(1) << cur.next_row);

endmodule

@@ design/kpsd_checker.sv @@
`timescale 1ns / 1ps

module kpsd_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [kpsd_pkg::NUM_ROWS-1:0] rsp_row_drive,
   input logic                          rsp_key_event,
   input logic [kpsd_pkg::CODE_W-1:0]   rsp_key_code
);

   // exactly one row is driven low
   a_row_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot(~rsp_row_drive))
      else $error("row drive not one-hot low");

   // no event means a zero code
   a_code_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_key_event) |-> (rsp_key_code == '0))
      else $error("key code set without event");

   // the lock forbids events on consecutive ticks
   a_no_double_event: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_key_event) |=> !(rsp_valid && rsp_key_event))
      else $error("key events on consecutive ticks");

   // consecutive results rotate the driven row upward
   a_row_rotate: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall) ##1 rsp_valid |->
         (rsp_row_drive == {$past(rsp_row_drive[2:0]), $past(rsp_row_drive[3])}))
      else $error("row sequence broken");

   // a stalled result holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_row_drive)
                                    && $stable(rsp_key_event) && $stable(rsp_key_code)))
      else $error("stalled result changed");

endmodule

bind matrix_keypad_scan_debounce_unit kpsd_checker u_kpsd_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_row_drive (rsp_row_drive),
   .rsp_key_event (rsp_key_event),
   .rsp_key_code  (rsp_key_code)
);
